// ===== src/center_crop_bilinear_upscale_x2_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for center_crop_bilinear_upscale_x2
// Short forms for same-cycle and next-cycle implications on clk, reset by rst.
// ----------------------------------------------------------------------------
`ifndef CENTER_CROP_BILINEAR_UPSCALE_X2_ASSERT_SVH
`define CENTER_CROP_BILINEAR_UPSCALE_X2_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CCBU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CCBU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ccbu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbu_pkg
// Types, sizes and register codes shared by the crop and 2x upscale block.
// ----------------------------------------------------------------------------
package ccbu_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;

  localparam int SIZE_W      = 12;                      // config register width
  localparam int PIX_W       = 8;
  localparam int OUT_W       = 11;                      // destination coordinate
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int STORE_DEPTH = (MAX_WIDTH >> 1) + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int XH_W        = $clog2(MAX_WIDTH >> 1);  // window column - 1
  localparam int YH_W        = $clog2(MAX_HEIGHT >> 1); // window row - 1
  localparam int IDX_W       = 1;                       // config index width

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(1080);

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    SUB_TOP_LEFT  = 2'd0,
    SUB_TOP_RIGHT = 2'd1,
    SUB_BOT_LEFT  = 2'd2,
    SUB_BOT_RIGHT = 2'd3
  } sub_pos_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } src_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_x;
    logic [OUT_W-1:0] out_y;
    logic [PIX_W-1:0] value;
    logic             last_of_run;
  } dst_word_t;

  // One 2x2 neighborhood handed to the output sequencer.
  typedef struct packed {
    logic [XH_W-1:0]  xh;
    logic [YH_W-1:0]  yh;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] d;
  } grp_t;

endpackage

// ===== src/ccbu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbu_ram
// Generic single-clock RAM, one write and one read port, registered read.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module ccbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== src/ccbu_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbu_emit
// Output sequencer: holds one 2x2 neighborhood and sends its four words.
// ----------------------------------------------------------------------------
module ccbu_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ccbu_pkg::grp_t    load_grp,
  output logic              free,
  output logic              dst_valid,
  input  logic              dst_stall,
  output ccbu_pkg::dst_word_t dst_word
);
  import ccbu_pkg::*;

  logic     grp_valid;
  sub_pos_t sub;
  sub_pos_t sub_next;
  grp_t     grp;

  logic [PIX_W:0]   sum_ar;
  logic [PIX_W:0]   sum_ab;
  logic [PIX_W+1:0] sum_all;
  logic [PIX_W-1:0] value;
  logic             send;

  assign send = grp_valid && !dst_stall;
  assign free = !grp_valid || (send && sub == SUB_BOT_RIGHT);

  always_comb begin
    case (sub)
      SUB_TOP_LEFT:  sub_next = SUB_TOP_RIGHT;
      SUB_TOP_RIGHT: sub_next = SUB_BOT_LEFT;
      SUB_BOT_LEFT:  sub_next = SUB_BOT_RIGHT;
      default:       sub_next = SUB_TOP_LEFT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      sub       <= SUB_TOP_LEFT;
    end else if (load) begin
      grp_valid <= 1'b1;
      sub       <= SUB_TOP_LEFT;
    end else if (send) begin
      grp_valid <= (sub != SUB_BOT_RIGHT);
      sub       <= sub_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= load_grp;
    end
  end

  assign sum_ar  = {1'b0, grp.a} + {1'b0, grp.r};
  assign sum_ab  = {1'b0, grp.a} + {1'b0, grp.b};
  assign sum_all = {1'b0, sum_ar} + {2'b00, grp.b} + {2'b00, grp.d};

  always_comb begin
    case (sub)
      SUB_TOP_LEFT:  value = grp.a;
      SUB_TOP_RIGHT: value = sum_ar[PIX_W:1];
      SUB_BOT_LEFT:  value = sum_ab[PIX_W:1];
      default:       value = sum_all[PIX_W+1:2];
    endcase
  end

  // Destination is (2y + row bit, 2x + column bit) of the source pixel.
  assign dst_valid            = grp_valid;
  assign dst_word.out_x       = OUT_W'({grp.xh, sub[0]});
  assign dst_word.out_y       = OUT_W'({grp.yh, sub[1]});
  assign dst_word.value       = value;
  assign dst_word.last_of_run = (sub == SUB_BOT_RIGHT);

endmodule

// ===== src/center_crop_bilinear_upscale_x2.sv =====
`timescale 1ns / 1ps
// Output: a window pixel that completes a source pixel passes the combine stage
//   and the group register, then gives its four words through the one-word
//   output port, one per cycle while dst_stall is low. Pixels outside the
//   window, and the first window row and column, go one per cycle unless stalled.
// Reset: rst (synchronous) restores 1920x1080, zeroes counters and neighbor
//   registers, empties the pipe. The line store is not cleared.
// ----------------------------------------------------------------------------
// center_crop_bilinear_upscale_x2
// Center crop of a raster pixel stream followed by a 2x bilinear upscale.
// ----------------------------------------------------------------------------
module center_crop_bilinear_upscale_x2 (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_we,
  input  logic [ccbu_pkg::IDX_W-1:0] cfg_index,
  input  logic [ccbu_pkg::SIZE_W-1:0] cfg_data,
  // incoming frame pixels
  input  logic                       src_valid,
  output logic                       src_stall,
  input  ccbu_pkg::src_word_t        src_word,
  // upscaled output pixels
  output logic                       dst_valid,
  input  logic                       dst_stall,
  output ccbu_pkg::dst_word_t        dst_word
);
  import ccbu_pkg::*;

  `include "center_crop_bilinear_upscale_x2_assert.svh"

  // Effective sizes are one bit wider than the counters so MAX itself fits.
  localparam int WD_W = COL_W + 1;
  localparam int HD_W = ROW_W + 1;

  // ---------------------------------------------------------------- config
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Clamp: zero acts as one, anything above the maximum acts as the maximum.
  logic [WD_W-1:0] w_eff;
  logic [HD_W-1:0] h_eff;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WD_W'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_eff = WD_W'(MAX_WIDTH);
    end else begin
      w_eff = WD_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HD_W'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HD_W'(MAX_HEIGHT);
    end else begin
      h_eff = HD_W'(frame_height);
    end
  end

  // ------------------------------------------------------- position stage
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] column_count_next;
  logic [ROW_W-1:0] row_count_next;

  logic [WD_W-1:0]  col_cur;   // position of this word, after frame_start
  logic [HD_W-1:0]  row_cur;
  logic [WD_W-1:0]  win_x0;
  logic [HD_W-1:0]  win_y0;
  logic [WD_W-1:0]  win_col;
  logic [HD_W-1:0]  win_row;
  logic [WD_W-1:0]  win_col_m1;
  logic [HD_W-1:0]  win_row_m1;
  logic [WD_W-1:0]  col_inc;
  logic [HD_W-1:0]  row_inc;
  logic             in_win;
  logic             completes;
  logic             src_accept;

  assign col_cur    = src_word.frame_start ? '0 : {1'b0, column_count};
  assign row_cur    = src_word.frame_start ? '0 : {1'b0, row_count};
  assign win_x0     = w_eff >> 2;
  assign win_y0     = h_eff >> 2;
  assign win_col    = col_cur - win_x0;
  assign win_row    = row_cur - win_y0;
  assign win_col_m1 = win_col - WD_W'(1);
  assign win_row_m1 = win_row - HD_W'(1);

  // Window is (W/2 + 1) x (H/2 + 1) pixels starting at (W/4, H/4).
  assign in_win = (col_cur >= win_x0) && (row_cur >= win_y0) &&
                  (win_col <= (w_eff >> 1)) && (win_row <= (h_eff >> 1));

  // Window pixel (y+1, x+1) completes source pixel (y, x).
  assign completes = in_win && (win_col != '0) && (win_row != '0);

  // Advance the raster position; wrap column at width, row at height.
  assign col_inc = col_cur + WD_W'(1);
  assign row_inc = row_cur + HD_W'(1);

  always_comb begin
    if (col_inc >= w_eff) begin
      column_count_next = '0;
      if (row_inc >= h_eff) begin
        row_count_next = '0;
      end else begin
        row_count_next = row_inc[ROW_W-1:0];
      end
    end else begin
      column_count_next = col_inc[COL_W-1:0];
      row_count_next    = row_cur[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (src_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // ------------------------------------------------------------ line store
  // Read the pixel above and write this one at the same column at the same edge;
  // the RAM returns the old entry, so no forwarding is needed. Read enable
  // follows acceptance so the read data holds while the next stage waits.
  logic             store_access;
  logic [PIX_W-1:0] above;

  assign store_access = src_accept && in_win;

  ccbu_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (store_access),
    .waddr (win_col[ADDR_W-1:0]),
    .wdata (src_word.pixel),
    .re    (store_access),
    .raddr (win_col[ADDR_W-1:0]),
    .rdata (above)
  );

  // --------------------------------------------------------- combine stage
  logic             s1_valid;
  logic             s1_completes;
  logic [PIX_W-1:0] s1_pixel;
  logic [XH_W-1:0]  s1_xh;
  logic [YH_W-1:0]  s1_yh;
  logic             s1_adv;
  logic             emit_free;
  logic             emit_load;
  grp_t             emit_grp;

  logic [PIX_W-1:0] left_pixel;
  logic [PIX_W-1:0] upper_left_pixel;

  // Drop window pixels that complete nothing; hand the rest to the sequencer.
  assign s1_adv     = s1_valid && (!s1_completes || emit_free);
  assign emit_load  = s1_adv && s1_completes;
  assign src_stall  = s1_valid && !s1_adv;
  assign src_accept = src_valid && !src_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (store_access) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (store_access) begin
      s1_completes <= completes;
      s1_pixel     <= src_word.pixel;
      s1_xh        <= win_col_m1[XH_W-1:0];
      s1_yh        <= win_row_m1[YH_W-1:0];
    end
  end

  // Shift the 2x2 neighborhood one column to the right.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (s1_adv) begin
      left_pixel       <= s1_pixel;
      upper_left_pixel <= above;
    end
  end

  assign emit_grp.xh = s1_xh;
  assign emit_grp.yh = s1_yh;
  assign emit_grp.a  = upper_left_pixel;
  assign emit_grp.r  = above;
  assign emit_grp.b  = left_pixel;
  assign emit_grp.d  = s1_pixel;

  // ------------------------------------------------------------ output
  ccbu_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .load_grp  (emit_grp),
    .free      (emit_free),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

  // ------------------------------------------------------------ checks
  `CCBU_ASSERT_NOW(a_stall_needs_pending, src_stall, s1_valid, "stall with empty stage")
  `CCBU_ASSERT_NOW(a_last_is_odd_corner, dst_valid && dst_word.last_of_run, dst_word.out_x[0] && dst_word.out_y[0], "last word not at odd corner")
  `CCBU_ASSERT_NEXT(a_group_continues, dst_valid && !dst_stall && !dst_word.last_of_run, dst_valid, "group cut short")

endmodule
